@@ rtl/alrl_pkg.sv @@
// Shared types, widths and codes for the array linked record list.
package alrl_pkg;

  localparam int NUM_W  = 31;
  localparam int NAME_W = 64;
  localparam int CNT_W  = 7;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam int DEFAULT_MAX_ENTRIES = 64;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [NUM_W-1:0]  key_number;
    logic [NAME_W-1:0] record_name;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [NUM_W-1:0]  found_number;
    logic [NAME_W-1:0] found_name;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [NAME_W-1:0] name;
  } rec_t;

endpackage

@@ rtl/alrl_ram.sv @@
// Generic single write port RAM with registered read.
module alrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/alrl_ctrl.sv @@
// Sequencer, free-slot scan, list walk and slot storage of the record list.
module alrl_ctrl #(
  parameter int MAX_ENTRIES = alrl_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  alrl_pkg::cmd_t                     cmd,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]   cap,
  output logic                               busy,
  output logic                               done,
  output alrl_pkg::rsp_t                     rsp
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int IW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IW-1:0] END = IW'(MAX_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LINK, S_WALK} state_t;

  state_t state;

  logic [IW-1:0]                head;
  logic [IW-1:0]                tail;
  logic [IW-1:0]                count;
  logic [MAX_ENTRIES-1:0]       used;
  logic [alrl_pkg::OP_W-1:0]    op_q;
  logic [alrl_pkg::NUM_W-1:0]   key_q;
  logic [alrl_pkg::NAME_W-1:0]  name_q;
  logic [AW-1:0]                slot;
  logic [IW-1:0]                idx;
  logic [IW-1:0]                prev;
  logic [IW-1:0]                steps;

  logic                         rec_we;
  alrl_pkg::rec_t               rec_wdata;
  alrl_pkg::rec_t               rec_rd;
  logic                         next_we;
  logic [AW-1:0]                next_waddr;
  logic [IW-1:0]                next_wdata;
  logic [IW-1:0]                next_rd;
  logic [AW-1:0]                raddr;
  logic                         match;

  assign busy      = (state != S_IDLE);
  assign match     = (rec_rd.number == key_q);
  assign rec_wdata = '{number: key_q, name: name_q};

  always_comb begin
    rec_we     = 1'b0;
    next_we    = 1'b0;
    next_waddr = tail[AW-1:0];
    next_wdata = END;
    raddr      = head[AW-1:0];
    case (state)
      S_IDLE: begin
        raddr = head[AW-1:0];
      end
      S_SCAN: begin
        if (!used[slot]) begin
          rec_we = 1'b1;
          // hook the new slot behind the current tail
          if (tail != END) begin
            next_we    = 1'b1;
            next_waddr = tail[AW-1:0];
            next_wdata = IW'(slot);
          end
        end
      end
      S_LINK: begin
        next_we    = 1'b1;
        next_waddr = tail[AW-1:0];
        next_wdata = END;
      end
      S_WALK: begin
        // follow the link straight from the read data
        raddr = next_rd[AW-1:0];
        if (match && op_q == alrl_pkg::OP_REMOVE && prev != END) begin
          next_we    = 1'b1;
          next_waddr = prev[AW-1:0];
          next_wdata = next_rd;
        end
      end
      default: begin
        raddr = head[AW-1:0];
      end
    endcase
  end

  alrl_ram #(
    .WIDTH ($bits(alrl_pkg::rec_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (slot),
    .wdata (rec_wdata),
    .raddr (raddr),
    .rdata (rec_rd)
  );

  alrl_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_ENTRIES)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (raddr),
    .rdata (next_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      head  <= END;
      tail  <= END;
      count <= '0;
      used  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q   <= cmd.operation;
            key_q  <= cmd.key_number;
            name_q <= cmd.record_name;
            case (cmd.operation)
              alrl_pkg::OP_INSERT: begin
                if (count >= cap) begin
                  done <= 1'b1;
                  rsp  <= '{status: alrl_pkg::ST_FULL, found_number: '0, found_name: '0,
                            entry_count: alrl_pkg::CNT_W'(count)};
                end else begin
                  slot  <= '0;
                  state <= S_SCAN;
                end
              end
              alrl_pkg::OP_SEARCH, alrl_pkg::OP_REMOVE: begin
                if (head == END) begin
                  done <= 1'b1;
                  rsp  <= '{status: alrl_pkg::ST_NOT_FOUND, found_number: '0,
                            found_name: '0, entry_count: alrl_pkg::CNT_W'(count)};
                end else begin
                  idx   <= head;
                  prev  <= END;
                  steps <= '0;
                  state <= S_WALK;
                end
              end
              default: begin
                done <= 1'b1;
                rsp  <= '{status: alrl_pkg::ST_NOT_FOUND, found_number: '0,
                          found_name: '0, entry_count: alrl_pkg::CNT_W'(count)};
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!used[slot]) begin
            used[slot] <= 1'b1;
            if (tail == END) begin
              head <= IW'(slot);
            end
            tail  <= IW'(slot);
            count <= count + IW'(1);
            state <= S_LINK;
          end else if (IW'(slot) == cap - IW'(1)) begin
            // no free slot below the capacity
            done  <= 1'b1;
            rsp   <= '{status: alrl_pkg::ST_FULL, found_number: '0, found_name: '0,
                       entry_count: alrl_pkg::CNT_W'(count)};
            state <= S_IDLE;
          end else begin
            slot <= slot + AW'(1);
          end
        end
        S_LINK: begin
          done  <= 1'b1;
          rsp   <= '{status: alrl_pkg::ST_OK, found_number: '0, found_name: '0,
                     entry_count: alrl_pkg::CNT_W'(count)};
          state <= S_IDLE;
        end
        S_WALK: begin
          if (match) begin
            done <= 1'b1;
            if (op_q == alrl_pkg::OP_REMOVE) begin
              // unlink and free the matched slot
              if (prev == END) begin
                head <= next_rd;
              end
              if (tail == idx) begin
                tail <= prev;
              end
              used[idx[AW-1:0]] <= 1'b0;
              count <= count - IW'(1);
              rsp   <= '{status: alrl_pkg::ST_OK, found_number: rec_rd.number,
                         found_name: rec_rd.name,
                         entry_count: alrl_pkg::CNT_W'(count - IW'(1))};
            end else begin
              rsp <= '{status: alrl_pkg::ST_OK, found_number: rec_rd.number,
                       found_name: rec_rd.name, entry_count: alrl_pkg::CNT_W'(count)};
            end
            state <= S_IDLE;
          end else if (next_rd >= END || steps == END - IW'(1)) begin
            done  <= 1'b1;
            rsp   <= '{status: alrl_pkg::ST_NOT_FOUND, found_number: '0,
                       found_name: '0, entry_count: alrl_pkg::CNT_W'(count)};
            state <= S_IDLE;
          end else begin
            prev  <= idx;
            idx   <= next_rd;
            steps <= steps + IW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= END)
    else $error("record count above slot depth");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (head == END))
    else $error("head marker disagrees with record count");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (head == END) == (tail == END))
    else $error("head and tail markers disagree");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && cmd.operation == alrl_pkg::OP_INSERT && count >= cap)
    |=> (done && rsp.status == alrl_pkg::ST_FULL))
    else $error("insert into full list not refused at once");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while still working");
`endif

endmodule

@@ rtl/array_linked_record_list_unit.sv @@
// Top level of the array linked record list: capacity register and sequencer.
//
//  channel   signals                      direction  handshake
//  command   start, busy, cmd             in         taken when start && !busy
//  result    done, rsp                    out        one-cycle strobe on done
//  config    capacity_we, capacity_data   in         written when capacity_we
//
//  done rises in the cycle after start is taken for an insert refused on the record
//  count, an unknown operation, or a search or remove on an empty list. An insert
//  runs the free-slot scan from slot zero (one used mark a cycle), then links the
//  new slot and raises done, or is refused when all slots below the capacity are
//  held. A search or remove walks the list (one slot read a cycle) to a match or
//  its end. busy is high while the scan, link or walk runs and drops as done rises.
//  rst is synchronous; it empties the list and sets the capacity to 64.
//  The result beat cannot be held off; take it in the cycle that done marks.
module array_linked_record_list_unit #(
  parameter int MAX_ENTRIES = alrl_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  alrl_pkg::cmd_t                cmd,
  output logic                          busy,
  output logic                          done,
  output alrl_pkg::rsp_t                rsp,
  input  logic                          capacity_we,
  input  logic [alrl_pkg::CNT_W-1:0]    capacity_data
);

  localparam int IW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (IW > alrl_pkg::CNT_W) ? IW : alrl_pkg::CNT_W;

  logic [alrl_pkg::CNT_W-1:0] capacity;
  logic [EW-1:0]              cap_ext;
  logic [IW-1:0]              cap_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= alrl_pkg::CAPACITY_RESET;
    end else if (capacity_we) begin
      capacity <= capacity_data;
    end
  end

  // clamp the register into one .. MAX_ENTRIES
  assign cap_ext = EW'(capacity);

  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = IW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      cap_eff = IW'(MAX_ENTRIES);
    end else begin
      cap_eff = IW'(cap_ext);
    end
  end

  alrl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .cap   (cap_eff),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

endmodule

@@ test/record_list_monitor.sv @@
// Monitor for the record list: mirrors the linked list and checks every result beat.
module record_list_monitor
  import alrl_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  cmd_t             cmd,
  input  logic             done,
  input  rsp_t             rsp,
  input  logic             capacity_we,
  input  logic [CNT_W-1:0] capacity_data,
  output int               fail_count,
  output int               pending,
  output int               ok_count,
  output int               miss_count,
  output int               full_count
);

  // Mirror of the list held by the block.
  logic [NUM_W-1:0]  mir_number [MAX_ENTRIES];
  logic [NAME_W-1:0] mir_name [MAX_ENTRIES];
  int                mir_next [MAX_ENTRIES];
  bit                mir_used [MAX_ENTRIES];
  int                mir_head;
  int                mir_tail;
  int                mir_count;
  logic [CNT_W-1:0]  mir_capacity;

  rsp_t awaited_rsp [$];
  int   fails;
  int   beats_seen;
  int   n_ok;
  int   n_miss;
  int   n_full;

  // Apply one command to the mirror and return the result beat it should give.
  function automatic rsp_t list_outcome(cmd_t c);
    rsp_t r;
    int   lim;
    int   pos;
    int   idx;
    int   prev;
    int   steps;
    bit   hit;
    r = '0;
    r.status = ST_NOT_FOUND;
    case (c.operation)
      OP_INSERT: begin
        if (mir_capacity == '0) lim = 1;
        else if (int'(mir_capacity) > MAX_ENTRIES) lim = MAX_ENTRIES;
        else lim = int'(mir_capacity);
        pos = MAX_ENTRIES;
        // scan downwards so that the lowest free slot wins
        if (mir_count < lim)
          for (int i = lim - 1; i >= 0; i--)
            if (!mir_used[i]) pos = i;
        if (pos == MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          mir_number[pos] = c.key_number;
          mir_name[pos]   = c.record_name;
          mir_next[pos]   = MAX_ENTRIES;
          mir_used[pos]   = 1'b1;
          if (mir_tail < MAX_ENTRIES) mir_next[mir_tail] = pos;
          else mir_head = pos;
          mir_tail = pos;
          mir_count++;
          r.status = ST_OK;
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        idx   = mir_head;
        prev  = MAX_ENTRIES;
        steps = 0;
        hit   = 1'b0;
        while (!hit && idx < MAX_ENTRIES && steps < MAX_ENTRIES) begin
          if (mir_number[idx] == c.key_number) begin
            hit = 1'b1;
            r.status       = ST_OK;
            r.found_number = mir_number[idx];
            r.found_name   = mir_name[idx];
            if (c.operation == OP_REMOVE) begin
              if (prev < MAX_ENTRIES) mir_next[prev] = mir_next[idx];
              else mir_head = mir_next[idx];
              if (mir_tail == idx) mir_tail = prev;
              mir_used[idx] = 1'b0;
              mir_next[idx] = MAX_ENTRIES;
              if (mir_count > 0) mir_count--;
            end
          end else begin
            prev = idx;
            idx  = mir_next[idx];
            steps++;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(mir_count);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    bit   bad;
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) mir_used[i] = 1'b0;
      mir_head     = MAX_ENTRIES;
      mir_tail     = MAX_ENTRIES;
      mir_count    = 0;
      mir_capacity = CAPACITY_RESET;
      awaited_rsp.delete();
    end else begin
      if (capacity_we) mir_capacity = capacity_data;
      if (done) begin
        beats_seen++;
        case (rsp.status)
          ST_OK:        n_ok++;
          ST_NOT_FOUND: n_miss++;
          ST_FULL:      n_full++;
          default: ;
        endcase
        if (awaited_rsp.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("result beat %0d arrived with nothing awaited: st=%0d num=%h name=%h cnt=%0d",
                     beats_seen, rsp.status, rsp.found_number, rsp.found_name,
                     rsp.entry_count);
        end else begin
          want = awaited_rsp.pop_front();
          bad = (rsp.status !== want.status) || (rsp.found_number !== want.found_number) ||
                (rsp.found_name !== want.found_name) ||
                (rsp.entry_count !== want.entry_count);
          if (bad) begin
            fails++;
            if (fails <= 10) begin
              $display("result beat %0d mismatch", beats_seen);
              $display("  expected st=%0d num=%h name=%h cnt=%0d", want.status,
                       want.found_number, want.found_name, want.entry_count);
              $display("  actual   st=%0d num=%h name=%h cnt=%0d", rsp.status,
                       rsp.found_number, rsp.found_name, rsp.entry_count);
            end
          end
        end
      end
      if (start && !busy) awaited_rsp.push_back(list_outcome(cmd));
    end
    pending    <= awaited_rsp.size();
    fail_count <= fails;
    ok_count   <= n_ok;
    miss_count <= n_miss;
    full_count <= n_full;
  end

endmodule

@@ test/tb_array_linked_record_list_unit.sv @@
// Testbench top for the record list: clock, reset, command stimulus and verdict.
module tb_array_linked_record_list_unit;
  import alrl_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNKNOWN    = 2'd3;
  localparam logic [NUM_W-1:0] KEY_MAX       = '1;
  localparam int               QUIET_LIMIT   = 2000;
  localparam int               SETTLE_CYCLES = 70;
  localparam int               N_PHASES      = 8;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             start         = 1'b0;
  cmd_t             cmd           = '0;
  logic             capacity_we   = 1'b0;
  logic [CNT_W-1:0] capacity_data = '0;
  logic             busy;
  logic             done;
  rsp_t             rsp;

  int fail_count;
  int pending;
  int ok_count;
  int miss_count;
  int full_count;
  int quiet;
  int sent;
  int settings_used;
  int idle_pct;

  // Per phase: capacity written, sender idle percentage, commands, insert percentage.
  int phase_cap    [N_PHASES] = '{64, 10, 0, 127, 1, 65, 0, 64};
  int phase_idle   [N_PHASES] = '{0, 79, 34, 0, 79, 34, 0, 79};
  int phase_items  [N_PHASES] = '{220, 150, 150, 260, 150, 250, 220, 180};
  int phase_insert [N_PHASES] = '{70, 45, 45, 65, 50, 45, 50, 35};

  always #6 clk = ~clk;

  array_linked_record_list_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .busy          (busy),
    .done          (done),
    .rsp           (rsp),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data)
  );

  record_list_monitor #(
    .MAX_ENTRIES (DEFAULT_MAX_ENTRIES)
  ) i_monitor (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .done          (done),
    .rsp           (rsp),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .ok_count      (ok_count),
    .miss_count    (miss_count),
    .full_count    (full_count)
  );

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("no beat for %0d cycles, giving up", quiet);
        $display("tb_array_linked_record_list_unit NOT OK");
        $finish;
      end
    end
  end

  function automatic cmd_t junk_cmd();
    cmd_t c;
    c.operation   = OP_W'($urandom);
    c.key_number  = NUM_W'($urandom);
    c.record_name = {$urandom, $urandom};
    return c;
  endfunction

  function automatic cmd_t make_cmd(logic [OP_W-1:0] op, logic [NUM_W-1:0] key,
                                    logic [NAME_W-1:0] name);
    cmd_t c;
    c.operation   = op;
    c.key_number  = key;
    c.record_name = name;
    return c;
  endfunction

  // Keys mostly from a small pool so that searches and removes hit often.
  function automatic cmd_t random_cmd(int insert_pct);
    cmd_t c;
    int   pick;
    c = junk_cmd();
    pick = $urandom_range(99);
    if (pick < insert_pct) begin
      c.operation = OP_INSERT;
    end else begin
      pick = $urandom_range(19);
      if (pick == 0) c.operation = OP_UNKNOWN;
      else if (pick < 10) c.operation = OP_SEARCH;
      else c.operation = OP_REMOVE;
    end
    pick = $urandom_range(9);
    if (pick == 1) c.key_number = $urandom_range(1) ? KEY_MAX : '0;
    else if (pick > 1) c.key_number = NUM_W'($urandom_range(23));
    return c;
  endfunction

  // Hold the beat until taken, then idle the sender at random.
  task automatic issue(cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sent++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= junk_cmd();
      @(posedge clk);
    end
  endtask

  // Drop start and wait until every awaited result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] value);
    capacity_we   <= 1'b1;
    capacity_data <= value;
    @(posedge clk);
    capacity_we   <= 1'b0;
    capacity_data <= CNT_W'($urandom);
    settings_used++;
  endtask

  initial begin
    phase_cap[6] = $urandom_range(2, 63);
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Two slots: fill, refuse, reuse a freed slot, duplicates, empty list.
    set_capacity(7'd2);
    issue(make_cmd(OP_INSERT, '0, '0));
    issue(make_cmd(OP_INSERT, KEY_MAX, '1));
    issue(make_cmd(OP_INSERT, 31'd5, 64'h0123_4567_89AB_CDEF));
    issue(make_cmd(OP_SEARCH, '0, '1));
    issue(make_cmd(OP_SEARCH, KEY_MAX, '0));
    issue(make_cmd(OP_SEARCH, 31'd5, '0));
    issue(make_cmd(OP_REMOVE, KEY_MAX, '0));
    issue(make_cmd(OP_INSERT, 31'd5, 64'hA5A5_A5A5_A5A5_A5A5));
    issue(make_cmd(OP_INSERT, 31'd9, '0));
    issue(make_cmd(OP_REMOVE, '0, '0));
    issue(make_cmd(OP_INSERT, 31'd5, 64'h5A5A_5A5A_5A5A_5A5A));
    issue(make_cmd(OP_SEARCH, 31'd5, '0));
    issue(make_cmd(OP_REMOVE, 31'd5, '0));
    issue(make_cmd(OP_UNKNOWN, 31'd5, '1));
    issue(make_cmd(OP_SEARCH, 31'd5, '0));
    issue(make_cmd(OP_REMOVE, 31'd5, '0));
    issue(make_cmd(OP_REMOVE, 31'd5, '0));
    issue(make_cmd(OP_SEARCH, '0, '0));
    issue(make_cmd(OP_UNKNOWN, KEY_MAX, '1));
    issue(make_cmd(OP_INSERT, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555));
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(CNT_W'(phase_cap[p]));
      idle_pct = phase_idle[p];
      for (int n = 0; n < phase_items[p]; n++) issue(random_cmd(phase_insert[p]));
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d commands over %0d capacity settings, sender idle at 0, 34 and 79 percent",
             sent, settings_used);
    $display("results: %0d done or found, %0d not found, %0d refused as full, %0d failures",
             ok_count, miss_count, full_count, fail_count);
    if (fail_count == 0) begin
      $display("tb_array_linked_record_list_unit OK");
    end else begin
      $display("tb_array_linked_record_list_unit NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/alrl_pkg.sv
rtl/alrl_ram.sv
rtl/alrl_ctrl.sv
rtl/array_linked_record_list_unit.sv
test/record_list_monitor.sv
test/tb_array_linked_record_list_unit.sv
